// File: hw/rtl/pack_table_validator_top_assert.svh
// Assertion macros for the pack table validator.
`ifndef PACK_TABLE_VALIDATOR_TOP_ASSERT_SVH
`define PACK_TABLE_VALIDATOR_TOP_ASSERT_SVH

`ifndef SYNTH

`define PTV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define PTV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PTV_ASSERT_IMP(label, ante, cons, msg)

`define PTV_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/ptv_pkg.sv
package ptv_pkg;

    localparam int DEF_HEADER_BYTES = 8;
    localparam int DEF_ENTRY_BYTES  = 8;
    localparam int DEF_ALIGN_BYTES  = 4;

    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int CHECKED_W  = 17;
    localparam int FAULT_W    = 4;
    localparam int ACTION_W   = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = 8;

    localparam logic [ADDR_W-1:0]    PACK_VERSION = 32'd1;
    localparam logic [CHECKED_W-1:0] ENTRIES_SAT  = '1;

    localparam logic [ACTION_W-1:0] ACT_HEADER = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ENTRY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

    localparam logic [FAULT_W-1:0] FAULT_NONE      = 4'd0;
    localparam logic [FAULT_W-1:0] FAULT_NO_HEADER = 4'd1;
    localparam logic [FAULT_W-1:0] FAULT_VERSION   = 4'd2;
    localparam logic [FAULT_W-1:0] FAULT_BELOW_MIN = 4'd3;
    localparam logic [FAULT_W-1:0] FAULT_ABOVE_MAX = 4'd4;
    localparam logic [FAULT_W-1:0] FAULT_OFFSET    = 4'd5;
    localparam logic [FAULT_W-1:0] FAULT_SIZE      = 4'd6;
    localparam logic [FAULT_W-1:0] FAULT_TOTAL     = 4'd7;
    localparam logic [FAULT_W-1:0] FAULT_COUNT     = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT = 2'd2;

    localparam logic [ADDR_W-1:0] SIZE_LIMIT_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [COUNT_W-1:0] count_min;
        logic [COUNT_W-1:0] count_max;
        logic [ADDR_W-1:0]  entry_size_limit;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   format_version;
        logic [COUNT_W-1:0]  entry_count;
        logic [ADDR_W-1:0]   entry_offset;
        logic [ADDR_W-1:0]   entry_bytes;
        logic [ADDR_W-1:0]   total_bytes;
        logic [ADDR_W-1:0]   hdr_addr;
    } item_t;

endpackage

// File: hw/rtl/ptv_residue.sv
module ptv_residue #(
    parameter int ALIGN_BYTES = ptv_pkg::DEF_ALIGN_BYTES,
    parameter int IN_W        = 32,
    parameter int RES_W       = 2
) (
    input  logic [IN_W-1:0]  value,
    output logic [RES_W-1:0] residue
);
    import ptv_pkg::*;

    localparam int NB = (IN_W + 7) / 8;

    logic [NB*8-1:0]  value_ext;
    logic [RES_W-1:0] part [NB];
    logic [RES_W-1:0] fold [256];
    logic [SUM_W-1:0] part_sum;

    assign value_ext = (NB*8)'(value);

    for (genvar k = 0; k < NB; k++) begin : g_byte
        logic [RES_W-1:0] lut [256];
        for (genvar i = 0; i < 256; i++) begin : g_lut
            localparam longint unsigned V = (longint'(i) << (8 * k)) % ALIGN_BYTES;
            assign lut[i] = V[RES_W-1:0];
        end
        assign part[k] = lut[value_ext[8*k +: 8]];
    end

    for (genvar i = 0; i < 256; i++) begin : g_fold
        localparam longint unsigned F = longint'(i) % ALIGN_BYTES;
        assign fold[i] = F[RES_W-1:0];
    end

    always_comb begin
        part_sum = '0;
        for (int k = 0; k < NB; k++) begin
            part_sum = part_sum + SUM_W'(part[k]);
        end
    end

    assign residue = fold[part_sum];

endmodule

// File: hw/rtl/ptv_regs.sv
module ptv_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptv_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ptv_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ptv_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output ptv_pkg::cfg_t                   cfg
);
    import ptv_pkg::*;

    logic                 wr_en;
    logic [CFG_IDX_W-1:0] idx;
    logic [COUNT_W-1:0]   count_min_reg;
    logic [COUNT_W-1:0]   count_max_reg;
    logic [ADDR_W-1:0]    size_limit_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_min_reg  <= '0;
            count_max_reg  <= '0;
            size_limit_reg <= SIZE_LIMIT_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_COUNT_MIN:  count_min_reg  <= pwdata[COUNT_W-1:0];
                REG_COUNT_MAX:  count_max_reg  <= pwdata[COUNT_W-1:0];
                REG_SIZE_LIMIT: size_limit_reg <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_COUNT_MIN:  prdata = CFG_DATA_W'(count_min_reg);
            REG_COUNT_MAX:  prdata = CFG_DATA_W'(count_max_reg);
            REG_SIZE_LIMIT: prdata = CFG_DATA_W'(size_limit_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.count_min        = count_min_reg;
    assign cfg.count_max        = count_max_reg;
    assign cfg.entry_size_limit = size_limit_reg;

endmodule

// File: hw/rtl/ptv_prep.sv
module ptv_prep #(
    parameter int HEADER_BYTES = ptv_pkg::DEF_HEADER_BYTES,
    parameter int ENTRY_BYTES  = ptv_pkg::DEF_ENTRY_BYTES,
    parameter int ALIGN_BYTES  = ptv_pkg::DEF_ALIGN_BYTES,
    parameter int RES_W        = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ptv_pkg::ACTION_W-1:0]  s_action,
    input  logic [ptv_pkg::ADDR_W-1:0]    s_format_version,
    input  logic [ptv_pkg::COUNT_W-1:0]   s_entry_count,
    input  logic [ptv_pkg::ADDR_W-1:0]    s_entry_offset,
    input  logic [ptv_pkg::ADDR_W-1:0]    s_entry_bytes,
    input  logic [ptv_pkg::ADDR_W-1:0]    s_total_bytes,
    input  logic                          take,
    output logic                          item_valid,
    output ptv_pkg::item_t                item,
    output logic [RES_W-1:0]              item_bytes_res
);
    import ptv_pkg::*;

    logic [ADDR_W-1:0] hdr_base;
    logic [RES_W-1:0]  hdr_res;
    logic [ADDR_W-1:0] hdr_pad;
    logic [ADDR_W-1:0] hdr_addr;
    logic [RES_W-1:0]  bytes_res;
    logic              load;
    logic              item_valid_reg;
    logic              item_valid_next;
    item_t             item_reg;
    logic [RES_W-1:0]  bytes_res_reg;

    assign hdr_base = ADDR_W'(HEADER_BYTES) + ADDR_W'(ENTRY_BYTES) * ADDR_W'(s_entry_count);

    ptv_residue #(
        .ALIGN_BYTES (ALIGN_BYTES),
        .IN_W        (ADDR_W),
        .RES_W       (RES_W)
    ) u_hdr_res (
        .value   (hdr_base),
        .residue (hdr_res)
    );

    ptv_residue #(
        .ALIGN_BYTES (ALIGN_BYTES),
        .IN_W        (ADDR_W),
        .RES_W       (RES_W)
    ) u_bytes_res (
        .value   (s_entry_bytes),
        .residue (bytes_res)
    );

    // header table end never wraps, so pad without a carry
    assign hdr_pad  = (hdr_res != '0) ? ADDR_W'(ALIGN_BYTES) - ADDR_W'(hdr_res) : '0;
    assign hdr_addr = hdr_base + hdr_pad;

    assign s_ready = !item_valid_reg || take;
    assign load    = s_valid && s_ready;

    always_comb begin
        if (load) begin
            item_valid_next = 1'b1;
        end else if (take) begin
            item_valid_next = 1'b0;
        end else begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.action         <= s_action;
            item_reg.format_version <= s_format_version;
            item_reg.entry_count    <= s_entry_count;
            item_reg.entry_offset   <= s_entry_offset;
            item_reg.entry_bytes    <= s_entry_bytes;
            item_reg.total_bytes    <= s_total_bytes;
            item_reg.hdr_addr       <= hdr_addr;
            bytes_res_reg           <= bytes_res;
        end
    end

    assign item_valid     = item_valid_reg;
    assign item           = item_reg;
    assign item_bytes_res = bytes_res_reg;

endmodule

// File: hw/rtl/ptv_check.sv
module ptv_check #(
    parameter int ALIGN_BYTES = ptv_pkg::DEF_ALIGN_BYTES,
    parameter int RES_W       = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ptv_pkg::cfg_t                 cfg,
    input  logic                          item_valid,
    input  ptv_pkg::item_t                item,
    input  logic [RES_W-1:0]              item_bytes_res,
    output logic                          take,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_verdict_ready,
    output logic                          m_broken,
    output logic [ptv_pkg::FAULT_W-1:0]   m_fault_code
);
    import ptv_pkg::*;

    localparam longint unsigned WRAP_MOD = (longint'(1) << ADDR_W) % ALIGN_BYTES;
    localparam longint unsigned WRAP_FIX = (ALIGN_BYTES - WRAP_MOD) % ALIGN_BYTES;

    logic                 seen_reg,     seen_next;
    logic [COUNT_W-1:0]   expected_reg, expected_next;
    logic [CHECKED_W-1:0] checked_reg,  checked_next;
    logic [ADDR_W-1:0]    addr_reg,     addr_next;
    logic [RES_W-1:0]     addr_res_reg, addr_res_next;
    logic [FAULT_W-1:0]   fault_reg,    fault_next;
    logic                 m_valid_reg,  m_valid_next;
    logic                 verdict_reg;
    logic                 broken_reg;
    logic [FAULT_W-1:0]   code_reg;

    logic [ADDR_W:0]      sum_ext;
    logic [SUM_W-1:0]     res_mix;
    logic [RES_W-1:0]     sum_res;
    logic [ADDR_W-1:0]    pad;
    logic [ADDR_W:0]      pad_ext;
    logic [ADDR_W-1:0]    new_addr;
    logic [RES_W-1:0]     new_res;
    logic [FAULT_W-1:0]   fault_base;
    logic [FAULT_W-1:0]   raise;
    logic                 excess;

    assign take = item_valid && (!m_valid_reg || m_ready);

    // advance the address by the entry size, then pad; residues track wrap at 2^32
    assign sum_ext = {1'b0, addr_reg} + {1'b0, item.entry_bytes};
    assign res_mix = SUM_W'(addr_res_reg) + SUM_W'(item_bytes_res)
                   + (sum_ext[ADDR_W] ? SUM_W'(WRAP_FIX[RES_W-1:0]) : SUM_W'(0));

    ptv_residue #(
        .ALIGN_BYTES (ALIGN_BYTES),
        .IN_W        (SUM_W),
        .RES_W       (RES_W)
    ) u_sum_res (
        .value   (res_mix),
        .residue (sum_res)
    );

    assign pad      = (sum_res != '0) ? ADDR_W'(ALIGN_BYTES) - ADDR_W'(sum_res) : '0;
    assign pad_ext  = {1'b0, sum_ext[ADDR_W-1:0]} + {1'b0, pad};
    assign new_addr = pad_ext[ADDR_W-1:0];
    assign new_res  = pad_ext[ADDR_W] ? WRAP_FIX[RES_W-1:0] : '0;

    always_comb begin
        seen_next     = seen_reg;
        expected_next = expected_reg;
        checked_next  = checked_reg;
        addr_next     = addr_reg;
        addr_res_next = addr_res_reg;
        fault_base    = fault_reg;
        raise         = FAULT_NONE;
        excess        = checked_reg >= {1'b0, expected_reg};
        unique case (item.action)
            ACT_HEADER: begin
                fault_base    = FAULT_NONE;
                checked_next  = '0;
                seen_next     = 1'b1;
                expected_next = item.entry_count;
                addr_next     = item.hdr_addr;
                addr_res_next = '0;
                if (item.format_version != PACK_VERSION) begin
                    raise = FAULT_VERSION;
                end else if (cfg.count_min != '0 && item.entry_count < cfg.count_min) begin
                    raise = FAULT_BELOW_MIN;
                end else if (cfg.count_max != '0 && item.entry_count > cfg.count_max) begin
                    raise = FAULT_ABOVE_MAX;
                end
            end
            ACT_ENTRY: begin
                if (!seen_reg) begin
                    raise = FAULT_NO_HEADER;
                end else begin
                    if (checked_reg != ENTRIES_SAT) begin
                        checked_next = checked_reg + CHECKED_W'(1);
                    end
                    if (excess) begin
                        raise = FAULT_COUNT;
                    end else if (item.entry_offset != addr_reg) begin
                        raise = FAULT_OFFSET;
                    end else if (item.entry_bytes > cfg.entry_size_limit) begin
                        raise = FAULT_SIZE;
                    end else begin
                        addr_next     = new_addr;
                        addr_res_next = new_res;
                    end
                end
            end
            ACT_FINISH: begin
                if (!seen_reg) begin
                    raise = FAULT_NO_HEADER;
                end else if (checked_reg != {1'b0, expected_reg}) begin
                    raise = FAULT_COUNT;
                end else if (addr_reg != item.total_bytes) begin
                    raise = FAULT_TOTAL;
                end
            end
            default: ;
        endcase
        fault_next = (fault_base == FAULT_NONE) ? raise : fault_base;
    end

    always_comb begin
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= 1'b0;
            expected_reg <= '0;
            checked_reg  <= '0;
            addr_reg     <= '0;
            addr_res_reg <= '0;
            fault_reg    <= FAULT_NONE;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (take) begin
                seen_reg     <= seen_next;
                expected_reg <= expected_next;
                checked_reg  <= checked_next;
                addr_reg     <= addr_next;
                addr_res_reg <= addr_res_next;
                fault_reg    <= fault_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            verdict_reg <= (item.action == ACT_FINISH);
            broken_reg  <= (fault_next != FAULT_NONE);
            code_reg    <= fault_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_verdict_ready = verdict_reg;
    assign m_broken        = broken_reg;
    assign m_fault_code    = code_reg;

endmodule

// File: hw/rtl/pack_table_validator_top.sv
// channel  | dir | handshake         | payload
// s_       | in  | s_valid/s_ready   | action, format_version, entry_count,
//          |     |                   | entry_offset, entry_bytes, total_bytes
// m_       | out | m_valid/m_ready   | verdict_ready, broken, fault_code
// apb      | in  | psel/penable      | count_min, count_max, entry_size_limit
//
// One item per cycle while m_ready is high; a beat is registered in prep, then in check.
// The running-address add, pad and compare loop in the check stage sets that rate.
// aresetn is synchronous, active low; it clears the pipeline and archive state
// and loads the register reset values.
// With m_ready low the result holds, the input register takes one more beat,
// then s_ready drops.
`include "pack_table_validator_top_assert.svh"

module pack_table_validator_top #(
    parameter int HEADER_BYTES = ptv_pkg::DEF_HEADER_BYTES,
    parameter int ENTRY_BYTES  = ptv_pkg::DEF_ENTRY_BYTES,
    parameter int ALIGN_BYTES  = ptv_pkg::DEF_ALIGN_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ptv_pkg::ACTION_W-1:0]    s_action,
    input  logic [ptv_pkg::ADDR_W-1:0]      s_format_version,
    input  logic [ptv_pkg::COUNT_W-1:0]     s_entry_count,
    input  logic [ptv_pkg::ADDR_W-1:0]      s_entry_offset,
    input  logic [ptv_pkg::ADDR_W-1:0]      s_entry_bytes,
    input  logic [ptv_pkg::ADDR_W-1:0]      s_total_bytes,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_verdict_ready,
    output logic                            m_broken,
    output logic [ptv_pkg::FAULT_W-1:0]     m_fault_code,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptv_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ptv_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ptv_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import ptv_pkg::*;

    localparam int RES_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;

    cfg_t             cfg;
    item_t            item;
    logic             item_valid;
    logic             take;
    logic [RES_W-1:0] item_bytes_res;

    ptv_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptv_prep #(
        .HEADER_BYTES (HEADER_BYTES),
        .ENTRY_BYTES  (ENTRY_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .RES_W        (RES_W)
    ) u_prep (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_format_version (s_format_version),
        .s_entry_count    (s_entry_count),
        .s_entry_offset   (s_entry_offset),
        .s_entry_bytes    (s_entry_bytes),
        .s_total_bytes    (s_total_bytes),
        .take             (take),
        .item_valid       (item_valid),
        .item             (item),
        .item_bytes_res   (item_bytes_res)
    );

    ptv_check #(
        .ALIGN_BYTES (ALIGN_BYTES),
        .RES_W       (RES_W)
    ) u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .item_valid      (item_valid),
        .item            (item),
        .item_bytes_res  (item_bytes_res),
        .take            (take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict_ready (m_verdict_ready),
        .m_broken        (m_broken),
        .m_fault_code    (m_fault_code)
    );

    `PTV_ASSERT_IMP(a_broken_matches_code, m_valid, m_broken == |m_fault_code, "broken mismatch")
    `PTV_ASSERT_IMP(a_fault_code_range, m_valid, m_fault_code <= FAULT_COUNT, "bad fault code")
    `PTV_ASSERT_IMP(a_no_overrun, item_valid && m_valid && !m_ready, !s_ready, "input overrun")
    `PTV_ASSERT_NEXT(a_take_fills_output, take, m_valid, "result missing")

endmodule

// File: bench/pack_table_validator_top_tb.sv
module pack_table_validator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptv_pkg::*;

    localparam int HDR_B       = DEF_HEADER_BYTES;
    localparam int ENT_B       = DEF_ENTRY_BYTES;
    localparam int ALIGN_B     = DEF_ALIGN_BYTES;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_BEATS = 125;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   version;
        logic [COUNT_W-1:0]  count;
        logic [ADDR_W-1:0]   offset;
        logic [ADDR_W-1:0]   bytes;
        logic [ADDR_W-1:0]   total;
    } beat_t;

    typedef struct packed {
        logic               verdict;
        logic               broken;
        logic [FAULT_W-1:0] fault;
    } verdict_t;

    logic                  aclk             = 1'b0;
    logic                  aresetn          = 1'b0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic [ACTION_W-1:0]   s_action         = ACT_NONE;
    logic [ADDR_W-1:0]     s_format_version = '0;
    logic [COUNT_W-1:0]    s_entry_count    = '0;
    logic [ADDR_W-1:0]     s_entry_offset   = '0;
    logic [ADDR_W-1:0]     s_entry_bytes    = '0;
    logic [ADDR_W-1:0]     s_total_bytes    = '0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic                  m_verdict_ready;
    logic                  m_broken;
    logic [FAULT_W-1:0]    m_fault_code;
    logic                  psel             = 1'b0;
    logic                  penable          = 1'b0;
    logic                  pwrite           = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr            = '0;
    logic [CFG_DATA_W-1:0] pwdata           = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    pack_table_validator_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_format_version(s_format_version),
        .s_entry_count   (s_entry_count),
        .s_entry_offset  (s_entry_offset),
        .s_entry_bytes   (s_entry_bytes),
        .s_total_bytes   (s_total_bytes),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_verdict_ready (m_verdict_ready),
        .m_broken        (m_broken),
        .m_fault_code    (m_fault_code),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    beat_t    beat_q[$];
    verdict_t verdict_q[$];
    beat_t    cur_beat;
    verdict_t next_verdict;
    int       queued_beats     = 0;
    int       fail_count       = 0;
    int       quiet_cycles     = 0;
    int       send_gap         = 0;
    int       recv_stall       = 0;
    bit       sender_idle_on   = 1'b1;
    bit       receiver_idle_on = 1'b1;

    logic [COUNT_W-1:0]   lim_count_min  = '0;
    logic [COUNT_W-1:0]   lim_count_max  = '0;
    logic [ADDR_W-1:0]    lim_entry_size = SIZE_LIMIT_RESET;

    logic                 pk_header_seen = 1'b0;
    logic [COUNT_W-1:0]   pk_expected    = '0;
    logic [CHECKED_W-1:0] pk_checked     = '0;
    logic [ADDR_W-1:0]    pk_addr        = '0;
    logic [FAULT_W-1:0]   pk_fault       = FAULT_NONE;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic [ADDR_W-1:0] pad_align(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        r = a % ADDR_W'(ALIGN_B);
        if (r != 0)
            return a + (ADDR_W'(ALIGN_B) - r);
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] table_end(input logic [COUNT_W-1:0] n);
        return pad_align(ADDR_W'(HDR_B) + ADDR_W'(ENT_B) * ADDR_W'(n));
    endfunction

    function automatic void note_fault(input logic [FAULT_W-1:0] code);
        if (pk_fault == FAULT_NONE)
            pk_fault = code;
    endfunction

    function automatic verdict_t predict_verdict(input beat_t b);
        verdict_t v;
        logic     excess;
        case (b.action)
            ACT_HEADER: begin
                pk_fault       = FAULT_NONE;
                pk_checked     = '0;
                pk_header_seen = 1'b1;
                pk_expected    = b.count;
                pk_addr        = table_end(b.count);
                if (b.version != PACK_VERSION)
                    note_fault(FAULT_VERSION);
                else if (lim_count_min != 0 && b.count < lim_count_min)
                    note_fault(FAULT_BELOW_MIN);
                else if (lim_count_max != 0 && b.count > lim_count_max)
                    note_fault(FAULT_ABOVE_MAX);
            end
            ACT_ENTRY: begin
                if (!pk_header_seen) begin
                    note_fault(FAULT_NO_HEADER);
                end else begin
                    excess = pk_checked >= CHECKED_W'(pk_expected);
                    if (pk_checked != ENTRIES_SAT)
                        pk_checked = pk_checked + CHECKED_W'(1);
                    if (excess)
                        note_fault(FAULT_COUNT);
                    else if (b.offset != pk_addr)
                        note_fault(FAULT_OFFSET);
                    else if (b.bytes > lim_entry_size)
                        note_fault(FAULT_SIZE);
                    else
                        pk_addr = pad_align(pk_addr + b.bytes);
                end
            end
            ACT_FINISH: begin
                if (!pk_header_seen)
                    note_fault(FAULT_NO_HEADER);
                else if (pk_checked != CHECKED_W'(pk_expected))
                    note_fault(FAULT_COUNT);
                else if (pk_addr != b.total)
                    note_fault(FAULT_TOTAL);
            end
            default: ;
        endcase
        v.verdict = (b.action == ACT_FINISH);
        v.broken  = (pk_fault != FAULT_NONE);
        v.fault   = pk_fault;
        return v;
    endfunction

    function automatic int idle_draw(input bit on);
        return on ? int'($urandom_range(0, 6)) : 0;
    endfunction

    function automatic beat_t rand_beat(input logic [ACTION_W-1:0] act);
        beat_t b;
        b.action  = act;
        b.version = $urandom;
        b.count   = COUNT_W'($urandom);
        b.offset  = $urandom;
        b.bytes   = $urandom;
        b.total   = $urandom;
        return b;
    endfunction

    function automatic void push_beat(input beat_t b);
        beat_q.push_back(b);
        queued_beats++;
    endfunction

    function automatic void push_fixed(input logic [ACTION_W-1:0] act,
                                       input logic [ADDR_W-1:0] ver,
                                       input logic [COUNT_W-1:0] cnt,
                                       input logic [ADDR_W-1:0] off,
                                       input logic [ADDR_W-1:0] len,
                                       input logic [ADDR_W-1:0] tot);
        beat_t b;
        b = '{act, ver, cnt, off, len, tot};
        push_beat(b);
    endfunction

    function automatic void queue_archive();
        beat_t             b;
        logic [COUNT_W-1:0] n_ann;
        logic [ADDR_W-1:0]  addr;
        int                 n_send;
        int                 sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            n_ann = COUNT_W'($urandom_range(0, 6));
        else if (sel < 80)
            n_ann = ($urandom_range(0, 1) ? lim_count_min : lim_count_max)
                    + COUNT_W'($urandom_range(0, 2)) - COUNT_W'(1);
        else if (sel < 88)
            n_ann = '1;
        else
            n_ann = COUNT_W'($urandom);
        b = rand_beat(ACT_HEADER);
        b.count = n_ann;
        if ($urandom_range(0, 9) != 0)
            b.version = PACK_VERSION;
        else if ($urandom_range(0, 1))
            b.version = ADDR_W'($urandom_range(0, 2));
        push_beat(b);

        addr   = table_end(n_ann);
        n_send = (n_ann <= 12) ? int'(n_ann) : int'($urandom_range(0, 3));
        sel    = $urandom_range(0, 99);
        if (sel < 6)
            n_send++;
        else if (sel < 12 && n_send > 0)
            n_send--;

        for (int i = 0; i < n_send; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_beat(rand_beat(ACT_NONE));
            b = rand_beat(ACT_ENTRY);
            b.offset = addr;
            sel = $urandom_range(0, 99);
            if (sel < 70)
                b.bytes = $urandom_range(0, 40);
            else if (sel < 82)
                b.bytes = lim_entry_size + ADDR_W'($urandom_range(0, 2)) - ADDR_W'(1);
            else if (sel < 94)
                b.bytes = $urandom;
            else
                b.bytes = '0;
            if ($urandom_range(0, 24) == 0)
                b.offset = addr ^ (ADDR_W'(1) << $urandom_range(0, 31));
            push_beat(b);
            addr = pad_align(addr + b.bytes);
        end

        if ($urandom_range(0, 19) != 0) begin
            b = rand_beat(ACT_FINISH);
            if ($urandom_range(0, 9) != 0)
                b.total = addr;
            else if ($urandom_range(0, 1))
                b.total = addr ^ (ADDR_W'(1) << $urandom_range(0, 31));
            push_beat(b);
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1))
                    b.total = $urandom;
                push_beat(b);
            end
        end
    endfunction

    task automatic apb_cycle(input logic [CFG_IDX_W-1:0] idx, input logic wr,
                             input logic [CFG_DATA_W-1:0] data,
                             output logic [CFG_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] kept;
        logic [CFG_DATA_W-1:0] back;
        kept = (idx == REG_SIZE_LIMIT) ? value : {16'h0, value[15:0]};
        apb_cycle(idx, 1'b1, value, back);
        case (idx)
            REG_COUNT_MIN: lim_count_min = kept[COUNT_W-1:0];
            REG_COUNT_MAX: lim_count_max = kept[COUNT_W-1:0];
            default:       lim_entry_size = kept;
        endcase
        apb_cycle(idx, 1'b0, '0, back);
        if (back !== kept)
            report_mismatch("register readback", back, kept);
    endtask

    task automatic set_limits(input logic [COUNT_W-1:0] lo, input logic [COUNT_W-1:0] hi,
                              input logic [ADDR_W-1:0] size_cap);
        write_reg(REG_COUNT_MIN, {16'($urandom), lo});
        write_reg(REG_COUNT_MAX, {16'($urandom), hi});
        write_reg(REG_SIZE_LIMIT, size_cap);
    endtask

    task automatic wait_drained();
        while (beat_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready)
                verdict_q.push_back(predict_verdict(cur_beat));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    cur_beat = beat_q.pop_front();
                    s_action         <= cur_beat.action;
                    s_format_version <= cur_beat.version;
                    s_entry_count    <= cur_beat.count;
                    s_entry_offset   <= cur_beat.offset;
                    s_entry_bytes    <= cur_beat.bytes;
                    s_total_bytes    <= cur_beat.total;
                    s_valid          <= 1'b1;
                    send_gap = idle_draw(sender_idle_on);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with none expected",
                                    32'({m_verdict_ready, m_broken, m_fault_code}), '0);
                end else begin
                    next_verdict = verdict_q.pop_front();
                    if (m_verdict_ready !== next_verdict.verdict)
                        report_mismatch("verdict_ready", 32'(m_verdict_ready),
                                        32'(next_verdict.verdict));
                    if (m_broken !== next_verdict.broken)
                        report_mismatch("broken", 32'(m_broken),
                                        32'(next_verdict.broken));
                    if (m_fault_code !== next_verdict.fault)
                        report_mismatch("fault_code", 32'(m_fault_code),
                                        32'(next_verdict.fault));
                end
                recv_stall = idle_draw(receiver_idle_on);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("status: fail");
        $finish;
    end

    initial begin
        int target;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        push_fixed(ACT_ENTRY,  32'd7,        16'd3,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_FINISH, 32'd1,        16'd0,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_NONE,   32'd0,        16'd0,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_HEADER, PACK_VERSION, 16'd2,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_ENTRY,  32'd0,        16'd0,    32'd24,       32'd5,        32'd0);
        push_fixed(ACT_ENTRY,  32'd0,        16'd0,    32'd32,       32'hFFFFFFFF, 32'd0);
        push_fixed(ACT_FINISH, 32'd0,        16'd0,    32'd0,        32'd0,        32'd32);
        push_fixed(ACT_FINISH, 32'd0,        16'd0,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_HEADER, 32'd0,        16'd0,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_HEADER, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                   32'hFFFFFFFF);
        push_fixed(ACT_HEADER, PACK_VERSION, 16'hFFFF, 32'd0,        32'd0,        32'd0);
        push_fixed(ACT_HEADER, PACK_VERSION, 16'd1,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_ENTRY,  32'd0,        16'd0,    32'd17,       32'd0,        32'd0);
        push_fixed(ACT_HEADER, PACK_VERSION, 16'd1,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_ENTRY,  32'd0,        16'd0,    32'd16,       32'd3,        32'd0);
        push_fixed(ACT_ENTRY,  32'd0,        16'd0,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_HEADER, PACK_VERSION, 16'd2,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_ENTRY,  32'd0,        16'd0,    32'd24,       32'd8,        32'd0);
        push_fixed(ACT_FINISH, 32'd0,        16'd0,    32'd0,        32'd0,        32'd99);
        push_fixed(ACT_HEADER, PACK_VERSION, 16'd0,    32'd0,        32'd0,        32'd0);
        push_fixed(ACT_FINISH, 32'd0,        16'd0,    32'd0,        32'd0,        32'd8);
        push_fixed(ACT_ENTRY,  32'd0,        16'd0,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
        push_fixed(ACT_FINISH, 32'd0,        16'd0,    32'd0,        32'd0,        32'hFFFFFFFF);
        wait_drained();

        for (int phase = 1; phase <= 6; phase++) begin
            case (phase)
                1: set_limits(16'd2, 16'd5, 32'd64);
                2: set_limits(16'hFFFF, 16'hFFFF, 32'd0);
                3: set_limits(16'd0, 16'hFFFF, 32'hFFFFFFFF);
                4: set_limits(16'd1, 16'd1, 32'($urandom_range(16, 48)));
                5: set_limits(16'($urandom_range(0, 4)), 16'($urandom_range(0, 10)),
                              $urandom);
                default: set_limits(16'd0, 16'd0, SIZE_LIMIT_RESET);
            endcase
            case (phase)
                1: begin sender_idle_on = 1'b1; receiver_idle_on = 1'b1; end
                2: begin sender_idle_on = 1'b0; receiver_idle_on = 1'b0; end
                3: begin sender_idle_on = 1'b1; receiver_idle_on = 1'b0; end
                4: begin sender_idle_on = 1'b0; receiver_idle_on = 1'b1; end
                default: begin
                    sender_idle_on   = 1'($urandom_range(0, 1));
                    receiver_idle_on = 1'($urandom_range(0, 1));
                end
            endcase
            target = queued_beats + PHASE_BEATS;
            while (queued_beats < target)
                queue_archive();
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: pack_table_validator_top.f
+incdir+hw/rtl
hw/rtl/ptv_pkg.sv
hw/rtl/ptv_residue.sv
hw/rtl/ptv_regs.sv
hw/rtl/ptv_prep.sv
hw/rtl/ptv_check.sv
hw/rtl/pack_table_validator_top.sv
bench/pack_table_validator_top_tb.sv
